// ===== rtl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       track_end;
  } mtep_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] delta_ticks;
    logic [7:0]  opcode;
    logic [3:0]  channel;
    logic        all_channels;
    logic [7:0]  param_a;
    logic [7:0]  param_b;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic [31:0] tick_frames;
    logic        last;
  } mtep_out_t;

  localparam logic [2:0] KIND_HDR   = 3'd0;
  localparam logic [2:0] KIND_PAY   = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_EOT   = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [3:0] PH_DELAY  = 4'd0;
  localparam logic [3:0] PH_STATUS = 4'd1;
  localparam logic [3:0] PH_PA     = 4'd2;
  localparam logic [3:0] PH_PB     = 4'd3;
  localparam logic [3:0] PH_MTYPE  = 4'd4;
  localparam logic [3:0] PH_LEN    = 4'd5;
  localparam logic [3:0] PH_PAY    = 4'd6;
  localparam logic [3:0] PH_DONE   = 4'd7;

  localparam logic [0:0] CFG_OUTPUT_RATE = 1'd0;
  localparam logic [0:0] CFG_TPQ        = 1'd1;

  localparam int VLQ_MAX_BYTES = 4;

  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [17:0] RATE_RESET    = 18'd44100;
  localparam logic [14:0] TPQ_RESET     = 15'd480;

endpackage

// ===== rtl/midi_track_event_parser_unit.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Byte-serial standard MIDI file track parser with tempo conversion.
// ----------------------------------------------------------------------------
// One track byte is taken per transfer; each byte yields up to three results,
// which leave through a one-entry output register, one per cycle while
// out_ready lets them. A byte that gives no result frees the input at once, a
// byte with results once its last result has entered the output register,
// later while that register waits on out_ready. A set-tempo event (or a restart
// that changes the tempo) also runs tick_frames = tempo*rate / (tpq*1e6) through
// a shared restoring divider, one quotient bit per cycle: a 42-bit product is
// built by one 24x18 multiply and the divisor by one 15x20 multiply, then come
// 42 divide steps and one saturate step before the results go out (the divide
// is skipped when tpq is zero). The block is not ready while it works on a
// byte.
module midi_track_event_parser_unit
  import mtep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mtep_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mtep_out_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  localparam int QW = 42;   // one quotient bit per dividend bit

  state_t      state_r, state_nxt;
  logic [17:0] rate_r;
  logic [14:0] tpq_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [27:0] delay_r, delay_nxt;
  logic [2:0]  vcnt_r, vcnt_nxt;
  logic [27:0] len_r, len_nxt;
  logic [27:0] left_r, left_nxt;
  logic [7:0]  evop_r, evop_nxt;
  logic [7:0]  fp_r, fp_nxt;
  logic [23:0] tsh_r, tsh_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic        err_r, err_nxt;

  // staged results of the current byte
  mtep_out_t   res_r [3];
  mtep_out_t   res_nxt [3];
  logic [1:0]  nres_r, nres_nxt;
  logic [1:0]  idx_r;
  logic [1:0]  tslot_r, tslot_nxt;
  logic        need_div;

  // divider datapath
  logic [41:0] num_r;
  logic [34:0] den_r;
  logic [QW-1:0] quo_r;
  logic [34:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [35:0] rem_sh;
  logic [31:0] fpt_sat;

  mtep_out_t   out_r;
  logic        ov_r;
  mtep_out_t   emit_res;
  logic        emit_fire;

  // the output register parts the two sides: a byte's last result waiting there does not block input
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // ------------------------------------------------------------------ parser
  function automatic mtep_out_t blank(input logic [2:0] k);
    mtep_out_t o;
    o = '0;
    o.kind = k;
    return o;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        err;
    logic        is_st;
    logic [7:0]  lead;
    logic [7:0]  pb;
    logic [7:0]  hi;
    mtep_out_t   o;
    logic [1:0]  n;
    logic [27:0] acc;
    b = in_data.data_byte;
    err = 1'b0;
    n = '0;
    phase_nxt = phase_r; rs_nxt = rs_r; delay_nxt = delay_r; vcnt_nxt = vcnt_r;
    len_nxt = len_r; left_nxt = left_r; evop_nxt = evop_r; fp_nxt = fp_r;
    tsh_nxt = tsh_r; tempo_nxt = tempo_r; err_nxt = err_r;
    res_nxt[0] = '0; res_nxt[1] = '0; res_nxt[2] = '0;
    need_div = 1'b0;
    tslot_nxt = '0;
    is_st = 1'b0; lead = '0; pb = '0; hi = '0; o = '0; acc = '0;
    if (in_data.op) begin
      phase_nxt = PH_DELAY; rs_nxt = '0; delay_nxt = '0; vcnt_nxt = '0;
      len_nxt = '0; left_nxt = '0; evop_nxt = '0; fp_nxt = '0; tsh_nxt = '0;
      err_nxt = 1'b0;
      if (tempo_r != TEMPO_DEFAULT) begin
        tempo_nxt = TEMPO_DEFAULT;
        res_nxt[0] = blank(KIND_TEMPO);
        need_div = 1'b1;
        n = 2'd1;
      end
    end else if (err_r) begin
      res_nxt[0] = blank(KIND_ERR);
      n = 2'd1;
    end else if (phase_r != PH_DONE) begin
      unique case (phase_r)
        PH_DELAY: begin
          acc = (vcnt_r == '0) ? 28'd0 : delay_r;
          delay_nxt = {acc[20:0], b[6:0]};
          vcnt_nxt = vcnt_r + 3'd1;
          if (b[7]) begin
            if (vcnt_nxt >= 3'(VLQ_MAX_BYTES)) err = 1'b1;
          end else begin
            vcnt_nxt = '0;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          is_st = b[7];
          if (is_st) begin
            lead = b; rs_nxt = b;
          end else if (rs_r[7]) begin
            lead = rs_r;
          end else begin
            err = 1'b1;
          end
          if (!err) begin
            evop_nxt = lead;
            if (lead[7:4] != 4'hF) begin
              if (is_st) begin
                phase_nxt = PH_PA;
              end else begin
                fp_nxt = b;
                if (lead[7:4] == 4'hC || lead[7:4] == 4'hD) begin
                  o = '0; o.kind = KIND_HDR; o.delta_ticks = delay_r;
                  o.opcode = {lead[7:4], 4'h0}; o.channel = lead[3:0]; o.param_a = b;
                  res_nxt[0] = o; n = 2'd1;
                  phase_nxt = PH_DELAY;
                end else begin
                  phase_nxt = PH_PB;
                end
              end
            end else begin
              rs_nxt = '0;
              if (lead == 8'hFF) phase_nxt = PH_MTYPE;
              else if (lead == 8'hF0 || lead == 8'hF7) begin
                fp_nxt = '0; vcnt_nxt = '0; phase_nxt = PH_LEN;
              end else err = 1'b1;
            end
          end
        end
        PH_PA: begin
          fp_nxt = b;
          if (evop_r[7:4] == 4'hC || evop_r[7:4] == 4'hD) begin
            o = '0; o.kind = KIND_HDR; o.delta_ticks = delay_r;
            o.opcode = {evop_r[7:4], 4'h0}; o.channel = evop_r[3:0]; o.param_a = b;
            res_nxt[0] = o; n = 2'd1;
            phase_nxt = PH_DELAY;
          end else begin
            phase_nxt = PH_PB;
          end
        end
        PH_PB: begin
          hi = {evop_r[7:4], 4'h0};
          pb = b;
          if (hi == 8'h90 && b == 8'h00) begin
            hi = 8'h80; pb = 8'h40;
          end
          o = '0; o.kind = KIND_HDR; o.delta_ticks = delay_r; o.opcode = hi;
          o.channel = evop_r[3:0]; o.param_a = fp_r; o.param_b = pb;
          res_nxt[0] = o; n = 2'd1;
          phase_nxt = PH_DELAY;
        end
        PH_MTYPE: begin
          fp_nxt = b; vcnt_nxt = '0; phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          acc = (vcnt_r == '0) ? 28'd0 : len_r;
          len_nxt = {acc[20:0], b[6:0]};
          vcnt_nxt = vcnt_r + 3'd1;
          if (b[7]) begin
            if (vcnt_nxt >= 3'(VLQ_MAX_BYTES)) err = 1'b1;
          end else begin
            vcnt_nxt = '0;
            left_nxt = len_nxt;
            tsh_nxt = '0;
            o = '0; o.kind = KIND_HDR; o.delta_ticks = delay_r; o.opcode = evop_r;
            o.all_channels = 1'b1; o.param_a = (evop_r == 8'hFF) ? fp_r : 8'h00;
            o.payload_length = len_nxt;
            res_nxt[0] = o; n = 2'd1;
            phase_nxt = (len_nxt == '0) ? PH_DELAY : PH_PAY;
          end
        end
        PH_PAY: begin
          tsh_nxt = {tsh_r[15:0], b};
          o = '0; o.kind = KIND_PAY; o.delta_ticks = delay_r; o.opcode = evop_r;
          o.all_channels = 1'b1; o.param_a = (evop_r == 8'hFF) ? fp_r : 8'h00;
          o.payload_length = len_r; o.payload_byte = b;
          res_nxt[0] = o; n = 2'd1;
          left_nxt = left_r - 28'd1;
          if (left_nxt == '0) begin
            if (evop_r == 8'hFF && fp_r == 8'h51 && len_r == 28'd3 &&
                tsh_nxt != '0 && tsh_nxt != tempo_r) begin
              tempo_nxt = tsh_nxt;
              o.kind = KIND_TEMPO; o.payload_byte = '0;
              res_nxt[1] = o; n = 2'd2;
              need_div = 1'b1; tslot_nxt = 2'd1;
            end
            phase_nxt = PH_DELAY;
          end
        end
        default: err = 1'b1;
      endcase
      if (!err && in_data.track_end) begin
        if (phase_nxt == PH_DELAY && vcnt_nxt == '0) begin
          res_nxt[n] = blank(KIND_EOT);
          n = n + 2'd1;
          phase_nxt = PH_DONE;
        end else begin
          err = 1'b1;
        end
      end
      if (err) begin
        err_nxt = 1'b1;
        res_nxt[0] = blank(KIND_ERR); res_nxt[1] = '0; res_nxt[2] = '0;
        n = 2'd1; need_div = 1'b0;
      end
    end
    nres_nxt = n;
  end

  // --------------------------------------------------------------- divider
  assign rem_sh = {rem_r, num_r[41]};
  assign fpt_sat = (quo_r == '0) ? 32'd1 :
                   (|quo_r[QW-1:32]) ? 32'hFFFF_FFFF : quo_r[31:0];

  // ------------------------------------------------------------ output
  always_comb begin
    emit_res = res_r[idx_r];
    emit_res.last = (idx_r == nres_r - 2'd1);
  end

  assign emit_fire = (state_r == S_EMIT) && (!ov_r || out_ready);

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        if (nres_nxt == '0) state_nxt = S_IDLE;
        else if (need_div) state_nxt = S_MUL;
        else state_nxt = S_EMIT;
      end
      S_MUL:  state_nxt = (tpq_r == '0) ? S_FIN : S_DIV;
      S_DIV:  if (dcnt_r == 6'(QW - 1)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_EMIT;
      S_EMIT: if (emit_fire && idx_r == nres_r - 2'd1) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rate_r <= RATE_RESET; tpq_r <= TPQ_RESET;
      phase_r <= PH_DELAY; rs_r <= '0; delay_r <= '0; vcnt_r <= '0;
      len_r <= '0; left_r <= '0; evop_r <= '0; fp_r <= '0; tsh_r <= '0;
      tempo_r <= TEMPO_DEFAULT; err_r <= 1'b0;
      ov_r <= 1'b0; nres_r <= '0; idx_r <= '0;
      tslot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OUTPUT_RATE: rate_r <= cfg_wdata;
          CFG_TPQ:         tpq_r <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (emit_fire) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          phase_r <= phase_nxt; rs_r <= rs_nxt; delay_r <= delay_nxt;
          vcnt_r <= vcnt_nxt; len_r <= len_nxt; left_r <= left_nxt;
          evop_r <= evop_nxt; fp_r <= fp_nxt; tsh_r <= tsh_nxt;
          tempo_r <= tempo_nxt; err_r <= err_nxt;
          res_r <= res_nxt; nres_r <= nres_nxt; idx_r <= '0;
          tslot_r <= tslot_nxt;
        end
        S_MUL: begin
          num_r <= {18'd0, tempo_r} * {24'd0, rate_r};
          den_r <= {20'd0, tpq_r} * 35'd1000000;
          rem_r <= '0; quo_r <= '0; dcnt_r <= '0;
        end
        S_DIV: begin
          // restoring step on {rem, next numerator bit}
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= 35'(rem_sh - {1'b0, den_r});
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[34:0];
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          num_r <= {num_r[40:0], 1'b0};
          dcnt_r <= dcnt_r + 6'd1;
        end
        S_FIN: begin
          res_r[tslot_r].tick_frames <= (tpq_r == '0) ? 32'd1000 : fpt_sat;
        end
        S_EMIT: if (emit_fire) begin
          out_r <= emit_res;
          idx_r <= idx_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI track event parser: a directed table of
// track bytes and short error cases, then random well-formed events with
// noise, all scored against a behavioral parser model kept in this module.
// ----------------------------------------------------------------------------
module tb_top;
  import mtep_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  // directed row: byte, restart/end flags, optional typed-in kind
  typedef struct {
    logic       op;
    logic [7:0] b;
    logic       te;
    logic       chk;   // 1: first result kind typed in below
    logic [2:0] k;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mtep_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mtep_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_OUTPUT_RATE;
  logic [17:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  midi_track_event_parser_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Parser model state (mirrors the block's architectural state)
  // ---------------------------------------------------------------------------
  logic [17:0] rate_q;
  logic [14:0] tpq_q;
  logic [3:0]  ph;
  logic [7:0]  run_st, ev_op, par1;
  logic [27:0] delay_acc, len_acc, pay_left;
  logic [2:0]  vcnt;
  logic [23:0] tshift, tempo_q;
  logic        err_q;

  mtep_out_t expected_q[$];
  int        n_fail = 0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_tempo = 0;
  int        n_errors = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;
  int        last_nres = 0;       // results predicted for the latest byte
  logic [2:0] last_kind = '0;     // kind of its first result

  function automatic logic [31:0] tick_frames_of(logic [23:0] t);
    logic [63:0] num, den, q;
    if (tpq_q == 0) return 32'd1000;
    num = 64'(t) * 64'(rate_q);
    den = 64'(tpq_q) * 64'd1000000;
    q = num / den;
    if (q < 1) q = 1;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic mtep_out_t bare_result(logic [2:0] k);
    mtep_out_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic mtep_out_t channel_result(logic [7:0] pb, bit second);
    mtep_out_t r;
    r = '0;
    r.kind = KIND_HDR;
    r.delta_ticks = delay_acc;
    r.opcode = {ev_op[7:4], 4'h0};
    r.channel = ev_op[3:0];
    r.param_a = par1;
    r.param_b = pb;
    // note-on with zero velocity reads as note-off, velocity 64
    if (ev_op[7:4] == 4'h9 && pb == 8'h00 && second) begin
      r.opcode = 8'h80;
      r.param_b = 8'h40;
    end
    return r;
  endfunction

  function automatic mtep_out_t meta_result(logic [2:0] k, logic [7:0] pbyte,
                                            logic [31:0] fpt);
    mtep_out_t r;
    r = '0;
    r.kind = k;
    r.delta_ticks = delay_acc;
    r.opcode = ev_op;
    r.all_channels = 1'b1;
    r.param_a = (ev_op == 8'hFF) ? par1 : 8'h00;
    r.payload_length = len_acc;
    r.payload_byte = pbyte;
    r.tick_frames = fpt;
    return r;
  endfunction

  task automatic model_reset();
    ph = PH_DELAY; run_st = '0; delay_acc = '0; vcnt = '0; len_acc = '0;
    pay_left = '0; ev_op = '0; par1 = '0; tshift = '0; err_q = 1'b0;
  endtask

  // Advance the model by one accepted byte and queue what it must produce.
  task automatic predict_track_byte(mtep_in_t it);
    mtep_out_t res[$];
    logic [7:0] b;
    logic [7:0] lead;
    bit         bad;
    b = it.data_byte;
    bad = 1'b0;
    lead = '0;
    if (it.op) begin
      model_reset();
      if (tempo_q != TEMPO_DEFAULT) begin
        tempo_q = TEMPO_DEFAULT;
        res.push_back(bare_result(KIND_TEMPO));
        res[0].tick_frames = tick_frames_of(tempo_q);
        n_tempo++;
      end
    end else if (err_q) begin
      res.push_back(bare_result(KIND_ERR));
    end else if (ph != PH_DONE) begin
      case (ph)
        PH_DELAY: begin
          if (vcnt == 0) delay_acc = '0;
          delay_acc = {delay_acc[20:0], b[6:0]};
          vcnt = vcnt + 3'd1;
          if (b[7]) begin
            if (vcnt >= VLQ_MAX_BYTES) bad = 1'b1;
          end else begin
            vcnt = 0;
            ph = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            lead = b;
            run_st = b;
          end else if (run_st[7]) begin
            lead = run_st;
          end else begin
            bad = 1'b1;
          end
          if (!bad) begin
            ev_op = lead;
            if (lead[7:4] != 4'hF) begin
              if (b[7]) begin
                ph = PH_PA;
              end else begin
                par1 = b;
                if (lead[7:4] == 4'hC || lead[7:4] == 4'hD) begin
                  res.push_back(channel_result(8'h00, 1'b0));
                  ph = PH_DELAY;
                end else begin
                  ph = PH_PB;
                end
              end
            end else begin
              run_st = '0;
              if (lead == 8'hFF) begin
                ph = PH_MTYPE;
              end else if (lead == 8'hF0 || lead == 8'hF7) begin
                par1 = '0; vcnt = 0; ph = PH_LEN;
              end else begin
                bad = 1'b1;
              end
            end
          end
        end
        PH_PA: begin
          par1 = b;
          if (ev_op[7:4] == 4'hC || ev_op[7:4] == 4'hD) begin
            res.push_back(channel_result(8'h00, 1'b0));
            ph = PH_DELAY;
          end else begin
            ph = PH_PB;
          end
        end
        PH_PB: begin
          res.push_back(channel_result(b, 1'b1));
          ph = PH_DELAY;
        end
        PH_MTYPE: begin
          par1 = b; vcnt = 0; ph = PH_LEN;
        end
        PH_LEN: begin
          if (vcnt == 0) len_acc = '0;
          len_acc = {len_acc[20:0], b[6:0]};
          vcnt = vcnt + 3'd1;
          if (b[7]) begin
            if (vcnt >= VLQ_MAX_BYTES) bad = 1'b1;
          end else begin
            vcnt = 0;
            pay_left = len_acc;
            tshift = '0;
            res.push_back(meta_result(KIND_HDR, 8'h00, 32'd0));
            ph = (len_acc == 0) ? PH_DELAY : PH_PAY;
          end
        end
        PH_PAY: begin
          tshift = {tshift[15:0], b};
          res.push_back(meta_result(KIND_PAY, b, 32'd0));
          pay_left = pay_left - 28'd1;
          if (pay_left == 0) begin
            // set-tempo of length 3 with a fresh nonzero value
            if (ev_op == 8'hFF && par1 == 8'h51 && len_acc == 3 &&
                tshift != 0 && tshift != tempo_q) begin
              tempo_q = tshift;
              res.push_back(meta_result(KIND_TEMPO, 8'h00, tick_frames_of(tempo_q)));
              n_tempo++;
            end
            ph = PH_DELAY;
          end
        end
        default: bad = 1'b1;
      endcase
      if (!bad && it.track_end) begin
        if (ph == PH_DELAY && vcnt == 0) begin
          res.push_back(bare_result(KIND_EOT));
          ph = PH_DONE;
        end else begin
          bad = 1'b1;
        end
      end
      if (bad) begin
        err_q = 1'b1;
        res.delete();
        res.push_back(bare_result(KIND_ERR));
        n_errors++;
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    last_nres = res.size();
    last_kind = (res.size() > 0) ? res[0].kind : KIND_HDR;
    foreach (res[i]) expected_q.push_back(res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: sample at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) idle_cycles <= 0;
    else if (!(rst_n && out_valid && out_ready)) idle_cycles <= idle_cycles + 1;
    else idle_cycles <= 0;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        n_fail++;
      end else begin
        if (out_data !== expected_q[0]) begin
          $display("%0t: result mismatch, expected %p, actual %p",
                   $time, expected_q[0], out_data);
          n_fail++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d transfers still expected", $time,
               expected_q.size());
      $display("midi_track_event_parser_unit regression: fail");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts until the quiet tail.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Returns at the falling edge after the transfer with valid still high; the
  // next call or drain_results changes it at that same edge.
  task automatic send_item(logic op, logic [7:0] b, logic te);
    mtep_in_t it;
    int burst;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (burst) @(negedge clk);
    end
    it.op = op; it.data_byte = b; it.track_end = te;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_track_byte(it);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    // let the block settle in idle before any register write
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [17:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_OUTPUT_RATE) rate_q = val;
    else tpq_q = val[14:0];
  endtask

  task automatic send_vlq(logic [27:0] v);
    if (v >= 28'h20_0000) send_item(1'b0, {1'b1, v[27:21]}, 1'b0);
    if (v >= 28'h4000) send_item(1'b0, {1'b1, v[20:14]}, 1'b0);
    if (v >= 28'h80) send_item(1'b0, {1'b1, v[13:7]}, 1'b0);
    send_item(1'b0, {1'b0, v[6:0]}, 1'b0);
  endtask

  // One random well-formed event; te marks its last byte as end of chunk.
  task automatic send_random_event(bit te);
    int sel, len;
    logic [7:0] st;
    logic [27:0] d;
    d = ($urandom_range(0, 7) == 0) ? 28'($urandom) : 28'($urandom_range(0, 300));
    send_vlq(d);
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      // at random, use running status when it matches the open channel status
      if (!(run_st == st && $urandom_range(0, 1))) send_item(1'b0, st, 1'b0);
      if (st[7:4] == 4'hC || st[7:4] == 4'hD) begin
        send_item(1'b0, {1'b0, 7'($urandom)}, te);
      end else begin
        send_item(1'b0, {1'b0, 7'($urandom)}, 1'b0);
        send_item(1'b0, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), te);
      end
    end else if (sel <= 7) begin
      send_item(1'b0, 8'hFF, 1'b0);
      if (sel == 6) begin
        send_item(1'b0, 8'h51, 1'b0);
        send_item(1'b0, 8'h03, 1'b0);
        send_item(1'b0, 8'($urandom), 1'b0);
        send_item(1'b0, 8'($urandom), 1'b0);
        send_item(1'b0, 8'($urandom), te);
      end else begin
        send_item(1'b0, 8'($urandom), 1'b0);
        len = $urandom_range(0, 4);
        send_item(1'b0, 8'(len), (len == 0) ? te : 1'b0);
        for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom), te && i == len - 1);
      end
    end else begin
      send_item(1'b0, (sel == 8) ? 8'hF0 : 8'hF7, 1'b0);
      len = $urandom_range(1, 3);
      send_item(1'b0, 8'(len), 1'b0);
      for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom), te && i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: extremes, note, program change and set-tempo events, restart, one error path
  // ---------------------------------------------------------------------------
  row_t dir_rows [25] = '{
    '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_HDR},  // delta with continuation
    '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'h7F, 1'b0, 1'b0, KIND_HDR},  // 4-byte max delta
    '{1'b0, 8'h9F, 1'b0, 1'b0, KIND_HDR},  // note-on ch 15
    '{1'b0, 8'h3C, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'h00, 1'b0, 1'b1, KIND_HDR},  // velocity 0 -> note-off
    '{1'b0, 8'h00, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'h3C, 1'b0, 1'b0, KIND_HDR},  // running status
    '{1'b0, 8'hFF, 1'b0, 1'b1, KIND_HDR},  // velocity with bit 7 set
    '{1'b0, 8'h00, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'hC0, 1'b0, 1'b0, KIND_HDR},  // program change, one data byte
    '{1'b0, 8'h05, 1'b0, 1'b1, KIND_HDR},
    '{1'b0, 8'h00, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_HDR},  // set tempo 0x0F4240
    '{1'b0, 8'h51, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'h03, 1'b0, 1'b1, KIND_HDR},
    '{1'b0, 8'h0F, 1'b0, 1'b1, KIND_PAY},
    '{1'b0, 8'h42, 1'b0, 1'b1, KIND_PAY},
    '{1'b0, 8'h40, 1'b1, 1'b1, KIND_PAY},  // ends chunk too
    '{1'b0, 8'h12, 1'b0, 1'b0, KIND_HDR},  // after end: ignored
    '{1'b1, 8'h00, 1'b0, 1'b1, KIND_TEMPO},// restart restores tempo
    '{1'b0, 8'h00, 1'b0, 1'b0, KIND_HDR},
    '{1'b0, 8'h40, 1'b0, 1'b1, KIND_ERR},  // data without running status
    '{1'b0, 8'h00, 1'b0, 1'b1, KIND_ERR}   // sticky
  };

  initial begin
    tempo_q = TEMPO_DEFAULT;
    rate_q = RATE_RESET;
    tpq_q = TPQ_RESET;
    model_reset();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: typed-in kind checked against the model's first result.
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].b, dir_rows[i].te);
      if (dir_rows[i].chk) begin
        if (last_nres == 0 || last_kind != dir_rows[i].k) begin
          $display("%0t: row %0d expected kind %0d, model disagrees", $time, i,
                   dir_rows[i].k);
          n_fail++;
        end
      end
    end
    // Short error cases: bad status, overlong VLQ, chunk cut inside event.
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hF4, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_item(1'b0, 8'h80, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hF0, 1'b0);
    for (int i = 0; i < 4; i++) send_item(1'b0, 8'h81, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);

    // Register extremes, then random values; each phase: full drain, restart, events, end.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0: begin write_register(CFG_OUTPUT_RATE, 18'd1); write_register(CFG_TPQ, 18'd32767); end
        1: begin write_register(CFG_OUTPUT_RATE, 18'd192000); write_register(CFG_TPQ, 18'd1); end
        2: begin write_register(CFG_OUTPUT_RATE, 18'h3FFFF); write_register(CFG_TPQ, 18'd0); end
        3: begin write_register(CFG_OUTPUT_RATE, 18'd48000); write_register(CFG_TPQ, 18'd96); end
        default: begin
          write_register(CFG_OUTPUT_RATE, 18'($urandom_range(1, 192000)));
          write_register(CFG_TPQ, 18'($urandom_range(1, 32767)));
        end
      endcase
      if (p == 5) no_idle = 1'b1;
      send_item(1'b1, 8'($urandom), 1'b0);
      for (int e = 0; e < 5; e++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));  // noise byte
        end else begin
          send_random_event(e == 4);
        end
        if (p == 2 && e == 2) drain_results();  // sender waits for quiet
      end
      send_item(1'b0, 8'($urandom), 1'b0);  // beyond end or after error
    end

    drain_results();
    $display("covered %0d track bytes, %0d results, %0d tempo changes, %0d errors",
             n_items, n_results, n_tempo, n_errors);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("midi_track_event_parser_unit regression: pass");
    end else begin
      $display("midi_track_event_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
